@@ design/bol_pkg.sv @@
// ----------------------------------------------------------------------------
// bol_pkg
// Shared types and constants for the bounded ordered list unit.
// ----------------------------------------------------------------------------
package bol_pkg;

  // default store depth
  localparam int DEPTH_DEF = 16;

  // payload widths
  localparam int DATA_W  = 32;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_ADD_FRONT = 2'd0,
    OP_ADD_BACK  = 2'd1,
    OP_REM_VALUE = 2'd2,
    OP_REM_LAST  = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH,
    S_SHFT,
    S_LRD,
    S_DONE
  } state_t;

endpackage

@@ design/bol_if.sv @@
// ----------------------------------------------------------------------------
// bol_if
// Request and result channel interfaces (valid / ready handshake).
// ----------------------------------------------------------------------------

// request channel: opcode and value
interface bol_in_if;
  import bol_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

// result channel: status, count, empty flag and back value
interface bol_out_if;
  import bol_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [COUNT_W-1:0]       count;
  logic                     is_empty;
  logic signed [DATA_W-1:0] last_value;

  modport source (output valid, output status, output count, output is_empty,
                  output last_value, input ready);
  modport sink   (input valid, input status, input count, input is_empty,
                  input last_value, output ready);
endinterface

@@ design/bol_ram.sv @@
// ----------------------------------------------------------------------------
// bol_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/bounded_ordered_list_unit.sv @@
// ----------------------------------------------------------------------------
// bounded_ordered_list_unit
// Ordered list of signed 32-bit values in a circular RAM of DEPTH entries.
// ----------------------------------------------------------------------------
// The list lives in one RAM used as a circular buffer, with a head pointer and
// an entry count in registers, so add front, add back and remove last each
// pass through accept, update, read of the back entry and result. Remove by
// value walks the list from the front through the single read port, one
// entry per cycle, then closes the gap by moving each later entry down one
// place, again one per cycle. One request is in flight at a time; the result
// register lets the next request be accepted while a result waits.
module bounded_ordered_list_unit #(
  parameter int DEPTH = bol_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bol_in_if.sink    in_ch,
  bol_out_if.source out_ch
);
  import bol_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  // control state
  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  status_t       status_r, status_nxt;

  // search and shift walkers
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] chk_idx_r, chk_idx_nxt;
  logic          chk_v_r, chk_v_nxt;
  logic [CW-1:0] src_r, src_nxt;
  logic [CW-1:0] wr_pos_r, wr_pos_nxt;
  logic          wr_pend_r, wr_pend_nxt;

  // latched request
  op_t               op_r;
  logic [DATA_W-1:0] val_r;

  // result register
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_empty_r;
  logic [DATA_W-1:0]  out_last_r;
  logic               out_load;

  // ram ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // list position to ram address, wrapping around the buffer
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] pos);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(pos);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  bol_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // handshake outputs
  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.count      = out_count_r;
  assign out_ch.is_empty   = out_empty_r;
  assign out_ch.last_value = out_last_r;

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      chk_v_r     <= 1'b0;
      wr_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      chk_v_r     <= chk_v_nxt;
      wr_pend_r   <= wr_pend_nxt;
    end
  end

  // walker and status registers
  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    idx_r     <= idx_nxt;
    chk_idx_r <= chk_idx_nxt;
    src_r     <= src_nxt;
    wr_pos_r  <= wr_pos_nxt;
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r  <= op_t'(in_ch.opcode);
      val_r <= in_ch.value;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= status_r;
      out_count_r  <= COUNT_W'(count_r);
      out_empty_r  <= (count_r == '0);
      out_last_r   <= (count_r == '0) ? '0 : ram_rdata;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    idx_nxt       = idx_r;
    chk_idx_nxt   = chk_idx_r;
    chk_v_nxt     = chk_v_r;
    src_nxt       = src_r;
    wr_pos_nxt    = wr_pos_r;
    wr_pend_nxt   = wr_pend_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = val_r;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_EXEC;
        end
      end

      // apply the request or start the search
      S_EXEC: begin
        status_nxt = ST_OK;
        state_nxt  = S_LRD;
        case (op_r)
          OP_ADD_FRONT: begin
            if (count_r == CW'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              head_nxt  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
              ram_we    = 1'b1;
              ram_waddr = head_nxt;
              count_nxt = count_r + CW'(1);
            end
          end
          OP_ADD_BACK: begin
            if (count_r == CW'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = phys(head_r, count_r);
              count_nxt = count_r + CW'(1);
            end
          end
          OP_REM_VALUE: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              idx_nxt   = '0;
              chk_v_nxt = 1'b0;
              state_nxt = S_SRCH;
            end
          end
          OP_REM_LAST: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              count_nxt = count_r - CW'(1);
            end
          end
          default: begin
            state_nxt = S_LRD;
          end
        endcase
      end

      // read one entry per cycle from the front, compare it in the next cycle
      S_SRCH: begin
        if (chk_v_r && (ram_rdata == val_r)) begin
          src_nxt     = chk_idx_r + CW'(1);
          wr_pend_nxt = 1'b0;
          chk_v_nxt   = 1'b0;
          state_nxt   = S_SHFT;
        end else if (chk_v_r && (chk_idx_r == count_r - CW'(1))) begin
          status_nxt = ST_NOT_FOUND;
          chk_v_nxt  = 1'b0;
          state_nxt  = S_LRD;
        end else if (idx_r < count_r) begin
          ram_re      = 1'b1;
          ram_raddr   = phys(head_r, idx_r);
          chk_idx_nxt = idx_r;
          chk_v_nxt   = 1'b1;
          idx_nxt     = idx_r + CW'(1);
        end else begin
          chk_v_nxt = 1'b0;
        end
      end

      // move each entry after the match down one place
      S_SHFT: begin
        if (wr_pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = phys(head_r, wr_pos_r);
          ram_wdata = ram_rdata;
        end
        if (src_r < count_r) begin
          ram_re      = 1'b1;
          ram_raddr   = phys(head_r, src_r);
          wr_pos_nxt  = src_r - CW'(1);
          wr_pend_nxt = 1'b1;
          src_nxt     = src_r + CW'(1);
        end else begin
          wr_pend_nxt = 1'b0;
          if (!wr_pend_r) begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_LRD;
          end
        end
      end

      // fetch the back entry
      S_LRD: begin
        if (count_r != '0) begin
          ram_re    = 1'b1;
          ram_raddr = phys(head_r, count_r - CW'(1));
        end
        state_nxt = S_DONE;
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
